// ===== rtl/pol_pkg.sv =====
// Shared types and constants for the positional ordered list.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package pol_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int FP_W      = 4;
  localparam int CNT_W     = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } pol_func_e;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             load_match;
    logic             shift_match;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } pol_ctrl_t;

  typedef struct packed {
    logic             ok;
    logic [FP_W-1:0]  found_pos;
    logic [CNT_W-1:0] count;
    logic             empty;
  } pol_res_t;

endpackage

// ===== rtl/pol_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors on insert and remove,
// and holds a match flag that shifts toward slot 0 during a search. Uses pol_pkg.
`timescale 1ns / 1ps

module pol_cell #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pol_pkg::pol_ctrl_t         ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0] count_i,
  input  logic [pol_pkg::VAL_W-1:0]  left_i,
  input  logic [pol_pkg::VAL_W-1:0]  right_i,
  input  logic                       match_right_i,
  output logic [pol_pkg::VAL_W-1:0]  data_o,
  output logic                       match_o
);
  import pol_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CmpW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CmpW-1:0] IdxC = CmpW'(IDX);

  logic [VAL_W-1:0] data_q, data_d;
  logic             match_q, match_d;
  logic [CmpW-1:0]  pos_ext, cnt_ext;

  assign pos_ext = CmpW'(ctrl_i.pos);
  assign cnt_ext = CmpW'(count_i);

  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    if (ctrl_i.ins) begin
      if (IdxC == pos_ext) begin
        data_d = ctrl_i.value;
      end else if (IdxC > pos_ext) begin
        data_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      if (IdxC >= pos_ext) begin
        data_d = right_i;
      end
    end
    if (ctrl_i.load_match) begin
      match_d = (data_q == ctrl_i.value) && (IdxC < cnt_ext);
    end else if (ctrl_i.shift_match) begin
      match_d = match_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ===== rtl/positional_ordered_list.sv =====
// Top level of the positional ordered list: command sequencer, entry count,
// output register and the chain of pol_cell slots. Uses pol_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   func_i, pos_i, value_i
//   out      source     out_valid_o / out_stall_i ok_o, found_pos_o, count_o, empty_res_o
//
// Insert and remove shift the slots at and after the position in parallel; clear
// only resets the count. Find loads a match flag into every slot below the count,
// then the flags shift one slot a cycle toward slot 0 until a hit or the end of the list.
// Reset clears the count, the state and the match flags; slot contents stay undefined until written.
// in_stall_o is high while a find scans or a result waits for the output
// register; a result waiting in the output register does not block input.
`timescale 1ns / 1ps

module positional_ordered_list #(
  parameter int DEPTH = pol_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       func_i,
  input  logic [pol_pkg::POS_W-1:0]        pos_i,
  input  logic signed [pol_pkg::VAL_W-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [pol_pkg::FP_W-1:0]         found_pos_o,
  output logic [pol_pkg::CNT_W-1:0]        count_o,
  output logic                             empty_res_o
);
  import pol_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CmpW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    idx_q, idx_d;
  pol_res_t         res_q, res, out_q;
  logic             out_valid_q, out_valid_d;
  logic             done, out_free, scan_last;
  logic             ins_ok, rem_ok;
  logic [CmpW-1:0]  pos_ext, cnt_ext;
  pol_func_e        func_e;
  pol_ctrl_t        ctrl;
  logic [VAL_W-1:0] data_w [DEPTH];
  logic [DEPTH-1:0] match_w;

  assign func_e    = pol_func_e'(func_i);
  assign pos_ext   = CmpW'(pos_i);
  assign cnt_ext   = CmpW'(count_q);
  assign ins_ok    = (pos_ext <= cnt_ext) && (count_q != CW'(DEPTH));
  assign rem_ok    = pos_ext < cnt_ext;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_last = (CW'(idx_q) + CW'(1)) >= count_q;

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    idx_d            = idx_q;
    done             = 1'b0;
    res              = '0;
    ctrl             = '0;
    ctrl.pos         = pos_i;
    ctrl.value       = value_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_e)
            FUNC_INSERT: begin
              ctrl.ins = ins_ok;
              if (ins_ok) count_d = count_q + CW'(1);
              res.ok   = ins_ok;
              done     = 1'b1;
            end
            FUNC_REMOVE: begin
              ctrl.rem = rem_ok;
              if (rem_ok) count_d = count_q - CW'(1);
              res.ok   = rem_ok;
              done     = 1'b1;
            end
            FUNC_FIND: begin
              ctrl.load_match = 1'b1;
              idx_d           = '0;
              state_d         = ST_SCAN;
            end
            FUNC_CLEAR: begin
              count_d = '0;
              res.ok  = 1'b1;
              done    = 1'b1;
            end
          endcase
          res.count = CNT_W'(count_d);
          res.empty = (count_d == '0);
        end
      end
      ST_SCAN: begin
        res.count = CNT_W'(count_q);
        res.empty = (count_q == '0);
        if (match_w[0]) begin
          res.ok        = 1'b1;
          res.found_pos = FP_W'(idx_q);
          done          = 1'b1;
        end else if (scan_last) begin
          done = 1'b1;
        end else begin
          ctrl.shift_match = 1'b1;
          idx_d            = idx_q + IW'(1);
        end
      end
      ST_HOLD: begin
        res  = res_q;
        done = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
    if (done) state_d = out_free ? ST_IDLE : ST_HOLD;
    out_valid_d = out_free ? done : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && out_free) out_q <= res;
    if (done && !out_free) res_q <= res;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_w, right_w;
    logic             mr_w;
    if (i == 0) begin : g_first
      assign left_w = data_w[0];
    end else begin : g_left
      assign left_w = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = data_w[DEPTH-1];
      assign mr_w    = 1'b0;
    end else begin : g_right
      assign right_w = data_w[i+1];
      assign mr_w    = match_w[i+1];
    end
    pol_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_i       (left_w),
      .right_i      (right_w),
      .match_right_i(mr_w),
      .data_o       (data_w[i]),
      .match_o      (match_w[i])
    );
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign ok_o        = out_q.ok;
  assign found_pos_o = out_q.found_pos;
  assign count_o     = out_q.count;
  assign empty_res_o = out_q.empty;

endmodule

// ===== rtl/pol_checker.sv =====
// Port-level checks for positional_ordered_list, attached by bind.
// Uses pol_pkg for field widths.
`timescale 1ns / 1ps

module pol_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [1:0]                       func_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             ok_o,
  input logic [pol_pkg::FP_W-1:0]         found_pos_o,
  input logic [pol_pkg::CNT_W-1:0]        count_o,
  input logic                             empty_res_o
);
  import pol_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(ok_o) && $stable(found_pos_o)
                                   && $stable(count_o) && $stable(empty_res_o))
    else $error("stalled output transaction changed");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> count_o == '0)
    else $error("empty result with nonzero count");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> found_pos_o == '0)
    else $error("failed result carries a found position");

  a_find_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_FIND |=> in_stall_o)
    else $error("input not held during a search");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);

// ===== tb/positional_ordered_list_tb.sv =====
// Testbench for positional_ordered_list: queued commands drive the input channel,
// and a shadow list predicts every result, which is checked at the output channel.
// Depends on pol_pkg and the positional_ordered_list RTL.
`timescale 1ns / 1ps

module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int RANDOM_CMDS    = 1650;
  localparam int CALM_TAIL      = 150;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 90;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    pol_func_e        func;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    logic             drain;
  } list_cmd_t;

  typedef struct {
    logic [VAL_W-1:0] ent [DEPTH];
    int               cnt;
  } list_state_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid    = 1'b0;
  pol_func_e               func_r      = FUNC_INSERT;
  logic [POS_W-1:0]        pos_r       = '0;
  logic signed [VAL_W-1:0] value_r     = '0;
  logic                    out_stall   = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic                    ok_o;
  logic [FP_W-1:0]         found_pos_o;
  logic [CNT_W-1:0]        count_o;
  logic                    empty_res_o;

  list_cmd_t   cmd_q [$];
  pol_res_t    due_results_q [$];
  list_state_t gen_list;
  list_state_t shadow_list;
  logic        drain_next  = 1'b0;
  int          total_cmds  = 0;
  int          n_in_acc    = 0;
  int          n_out_acc   = 0;
  int          gap_cnt     = 0;
  int          stall_cnt   = 0;
  int          hold_cnt    = 0;
  logic        hold_done   = 1'b0;
  int          quiet_cycles = 0;
  int          n_err       = 0;
  int          n_func [4];
  int          n_ok        = 0;
  logic        calm;

  positional_ordered_list u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .func_i      (func_r),
    .pos_i       (pos_r),
    .value_i     (value_r),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .ok_o        (ok_o),
    .found_pos_o (found_pos_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  assign calm = (n_in_acc + CALM_TAIL >= total_cmds);

  function automatic pol_res_t list_apply(inout list_state_t s, input list_cmd_t c);
    pol_res_t r;
    int       i;
    logic     hit;
    r   = '0;
    hit = 1'b0;
    case (c.func)
      FUNC_INSERT: begin
        if (c.pos <= s.cnt && s.cnt < DEPTH) begin
          for (i = s.cnt; i > c.pos; i--) s.ent[i] = s.ent[i-1];
          s.ent[c.pos] = c.value;
          s.cnt++;
          r.ok = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (c.pos < s.cnt) begin
          for (i = c.pos; i + 1 < s.cnt; i++) s.ent[i] = s.ent[i+1];
          s.cnt--;
          r.ok = 1'b1;
        end
      end
      FUNC_FIND: begin
        for (i = 0; i < s.cnt; i++) begin
          if (!hit && s.ent[i] == c.value) begin
            hit         = 1'b1;
            r.ok        = 1'b1;
            r.found_pos = FP_W'(i);
          end
        end
      end
      default: begin
        s.cnt = 0;
        r.ok  = 1'b1;
      end
    endcase
    r.count = CNT_W'(s.cnt);
    r.empty = (s.cnt == 0);
    return r;
  endfunction

  task automatic add_cmd(pol_func_e f, int p, logic [VAL_W-1:0] v);
    list_cmd_t c;
    c.func     = f;
    c.pos      = p[POS_W-1:0];
    c.value    = v;
    c.drain    = drain_next;
    drain_next = 1'b0;
    void'(list_apply(gen_list, c));
    cmd_q.push_back(c);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2:    return VAL_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] find_value();
    if (gen_list.cnt > 0 && $urandom_range(0, 2) != 0) begin
      return gen_list.ent[$urandom_range(0, gen_list.cnt - 1)];
    end
    return rand_value();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_err < 100) begin
      $display("mismatch at result %0d: %s got %0h want %0h", n_out_acc, what, got, want);
    end
    n_err++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic      taken;
    list_cmd_t cur;
    list_cmd_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
      n_in_acc <= 0;
    end else begin
      taken = in_valid && !in_stall_o;
      if (taken) begin
        cur.func  = func_r;
        cur.pos   = pos_r;
        cur.value = value_r;
        cur.drain = 1'b0;
        due_results_q.push_back(list_apply(shadow_list, cur));
        n_func[func_r]++;
        n_in_acc <= n_in_acc + 1;
      end
      if (!in_valid || taken) begin
        if (gap_cnt > 0) begin
          gap_cnt  <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (cmd_q[0].drain && (n_in_acc + int'(taken) != n_out_acc)) begin
          in_valid <= 1'b0;
        end else if (!calm && hold_cnt == 0 && $urandom_range(0, 15) == 0) begin
          gap_cnt  <= $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else begin
          nxt      = cmd_q.pop_front();
          in_valid <= 1'b1;
          func_r   <= nxt.func;
          pos_r    <= nxt.pos;
          value_r  <= nxt.value;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && n_out_acc >= HOLD_AT) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch
    pol_res_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
      n_out_acc <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (due_results_q.size() == 0) begin
          report_mismatch("result with nothing due", {31'b0, ok_o}, 32'b0);
        end else begin
          want = due_results_q.pop_front();
          if (ok_o !== want.ok) report_mismatch("ok", 32'(ok_o), 32'(want.ok));
          if (found_pos_o !== want.found_pos) begin
            report_mismatch("found_pos", 32'(found_pos_o), 32'(want.found_pos));
          end
          if (count_o !== want.count) begin
            report_mismatch("count", 32'(count_o), 32'(want.count));
          end
          if (empty_res_o !== want.empty) begin
            report_mismatch("empty_res", 32'(empty_res_o), 32'(want.empty));
          end
          if (want.ok) n_ok++;
        end
        n_out_acc <= n_out_acc + 1;
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_cnt <= $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int mode;
    int len;
    int r;
    int k;
    int next_drain_at;
    gen_list.cnt    = 0;
    shadow_list.cnt = 0;
    for (k = 0; k < 4; k++) n_func[k] = 0;

    // empty-list corners
    add_cmd(FUNC_FIND, 0, 32'h0000_0000);
    add_cmd(FUNC_REMOVE, 0, $urandom);
    add_cmd(FUNC_INSERT, 1, 32'h1234_5678);
    add_cmd(FUNC_CLEAR, 0, $urandom);
    // extremes, insert at head and at count, duplicates
    add_cmd(FUNC_INSERT, 0, 32'h8000_0000);
    add_cmd(FUNC_INSERT, 1, 32'h7fff_ffff);
    add_cmd(FUNC_INSERT, 0, 32'hffff_ffff);
    add_cmd(FUNC_INSERT, 3, 32'h0000_0000);
    add_cmd(FUNC_INSERT, 2, 32'h7fff_ffff);
    add_cmd(FUNC_FIND, 0, 32'h7fff_ffff);
    add_cmd(FUNC_FIND, 31, 32'h8000_0000);
    add_cmd(FUNC_FIND, 0, 32'h0000_0000);
    add_cmd(FUNC_FIND, 0, 32'h7fff_fffe);
    // out-of-range positions
    add_cmd(FUNC_REMOVE, 5, $urandom);
    add_cmd(FUNC_REMOVE, 31, $urandom);
    add_cmd(FUNC_INSERT, 31, 32'h5555_aaaa);
    add_cmd(FUNC_INSERT, 6, 32'haaaa_5555);
    // remove at tail and head
    add_cmd(FUNC_REMOVE, 4, $urandom);
    add_cmd(FUNC_REMOVE, 0, $urandom);
    add_cmd(FUNC_FIND, 0, 32'hffff_ffff);
    add_cmd(FUNC_CLEAR, 0, $urandom);
    add_cmd(FUNC_FIND, 0, 32'h0000_0000);

    next_drain_at = cmd_q.size();
    while (cmd_q.size() < RANDOM_CMDS) begin
      if (cmd_q.size() >= next_drain_at) begin
        drain_next    = 1'b1;
        next_drain_at = next_drain_at + 500;
      end
      mode = $urandom_range(0, 9);
      case (mode)
        6, 7: begin
          while (gen_list.cnt < DEPTH) begin
            add_cmd(FUNC_INSERT, $urandom_range(0, gen_list.cnt), rand_value());
          end
          repeat ($urandom_range(1, 3)) add_cmd(FUNC_INSERT, $urandom_range(0, DEPTH), rand_value());
          repeat ($urandom_range(1, 3)) add_cmd(FUNC_FIND, $urandom_range(0, 31), find_value());
          add_cmd(FUNC_REMOVE, DEPTH, $urandom);
          k = $urandom_range(0, 4);
          while (gen_list.cnt > k) begin
            add_cmd(FUNC_REMOVE, $urandom_range(0, gen_list.cnt - 1), $urandom);
          end
        end
        8: begin
          repeat ($urandom_range(3, 8)) begin
            add_cmd(pol_func_e'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
          end
        end
        9: begin
          repeat ($urandom_range(1, 4)) add_cmd(FUNC_FIND, 0, find_value());
          add_cmd(FUNC_CLEAR, $urandom_range(0, 31), $urandom);
        end
        default: begin
          len = $urandom_range(4, 20);
          repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
              add_cmd(FUNC_INSERT, $urandom_range(0, gen_list.cnt), rand_value());
            end else if (r < 65) begin
              if (gen_list.cnt > 0) begin
                add_cmd(FUNC_REMOVE, $urandom_range(0, gen_list.cnt - 1), $urandom);
              end else begin
                add_cmd(FUNC_REMOVE, 0, $urandom);
              end
            end else if (r < 97) begin
              add_cmd(FUNC_FIND, $urandom_range(0, 15), find_value());
            end else begin
              add_cmd(FUNC_CLEAR, $urandom_range(0, 31), $urandom);
            end
          end
        end
      endcase
    end
    total_cmds = cmd_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_in_acc != total_cmds || n_out_acc != n_in_acc) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_results_q.size() != 0) begin
      report_mismatch("results never delivered", due_results_q.size(), 32'b0);
    end

    $display("ran %0d commands: %0d insert, %0d remove, %0d find, %0d clear",
             n_in_acc, n_func[FUNC_INSERT], n_func[FUNC_REMOVE], n_func[FUNC_FIND],
             n_func[FUNC_CLEAR]);
    $display("checked %0d results, %0d succeeded, %0d mismatches", n_out_acc, n_ok, n_err);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
